>>> design/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types, event codes and character classes for the key/value text
// tokenizer.
// ----------------------------------------------------------------------------
package kvt_pkg;

  localparam int EVENT_W      = 3;
  localparam int TOKEN_BYTE_W = 8;
  localparam int TOKEN_LINE_W = 16;
  localparam int MAX_RESULTS  = 3;
  localparam int QUEUE_DEPTH  = 4;

  typedef enum logic [EVENT_W-1:0] {
    EV_SBYTE = 3'd0,
    EV_SEND  = 3'd1,
    EV_IBYTE = 3'd2,
    EV_IEND  = 3'd3,
    EV_LBR   = 3'd4,
    EV_RBR   = 3'd5,
    EV_EOT   = 3'd6
  } kvt_event_t;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;

  typedef struct packed {
    kvt_event_t              event_res;
    logic [TOKEN_BYTE_W-1:0] token_byte;
    logic [TOKEN_LINE_W-1:0] token_line;
    logic                    last_of_run;
  } kvt_result_t;

  // All results caused by one input byte, filled from entry 0 upwards.
  typedef struct packed {
    logic [1:0]                       count;
    kvt_result_t [MAX_RESULTS-1:0]    res;
  } kvt_batch_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic ident_more(input logic [7:0] c);
    return is_alnum(c) || c == CH_UNDERSCORE || c == CH_DASH || c == CH_DOT ||
           c == CH_COLON || c == CH_SLASH || c == CH_BACKSLASH;
  endfunction

endpackage

>>> design/kvt_lexer.sv
// ----------------------------------------------------------------------------
// kvt_lexer
// Lexer state and the single-pass step that turns one text byte into up to
// three results.
// ----------------------------------------------------------------------------
module kvt_lexer import kvt_pkg::*; #(
  parameter int STRING_BUFFER = 4096,
  parameter int LINE_BITS     = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] text_byte,
  output kvt_batch_t batch
);

  localparam int LEN_W = $clog2(STRING_BUFFER);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(STRING_BUFFER - 1);
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

  typedef enum logic [2:0] {
    M_IDLE, M_SLASH, M_COMMENT, M_IDENT, M_SINGLE, M_STRING, M_ESCAPE, M_CUT
  } mode_t;

  mode_t                mode, mode_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;
  logic [LINE_BITS-1:0] start_line, start_line_next;
  logic [LEN_W-1:0]     string_length, string_length_next;

  logic [TOKEN_LINE_W-1:0] cur_line, tok_line;
  logic [LEN_W-1:0]        len_inc;
  logic [7:0]              decoded;
  logic                    do_idle;
  logic                    do_sbyte;

  function automatic kvt_result_t mk(input kvt_event_t ev, input logic [7:0] b,
                                     input logic [TOKEN_LINE_W-1:0] ln);
    kvt_result_t r;
    r.event_res   = ev;
    r.token_byte  = b;
    r.token_line  = ln;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  assign cur_line = TOKEN_LINE_W'(line_count);
  assign tok_line = TOKEN_LINE_W'(start_line);
  assign len_inc  = string_length + LEN_W'(1);

  always_comb begin
    mode_next          = mode;
    line_count_next    = line_count;
    start_line_next    = start_line;
    string_length_next = string_length;
    batch              = '0;
    do_idle            = 1'b0;
    do_sbyte           = 1'b0;
    decoded            = text_byte;

    // Results that close the token in progress come first.
    unique case (mode)
      M_SLASH: begin
        if (text_byte == CH_SLASH) begin
          mode_next = M_COMMENT;
        end else begin
          batch.res[batch.count] = mk(EV_IBYTE, CH_SLASH, tok_line);
          batch.count = batch.count + 2'd1;
          batch.res[batch.count] = mk(EV_IEND, CH_NUL, tok_line);
          batch.count = batch.count + 2'd1;
          do_idle = 1'b1;
        end
      end
      M_COMMENT: begin
        if (text_byte == CH_NUL) begin
          do_idle = 1'b1;
        end else if (text_byte == CH_LF) begin
          if (line_count != LINE_MAX) line_count_next = line_count + LINE_ONE;
          mode_next = M_IDLE;
        end
      end
      M_IDENT: begin
        if (text_byte != CH_NUL && ident_more(text_byte)) begin
          batch.res[batch.count] = mk(EV_IBYTE, text_byte, tok_line);
          batch.count = batch.count + 2'd1;
        end else begin
          batch.res[batch.count] = mk(EV_IEND, CH_NUL, tok_line);
          batch.count = batch.count + 2'd1;
          do_idle = 1'b1;
        end
      end
      M_SINGLE: begin
        batch.res[batch.count] = mk(EV_IEND, CH_NUL, tok_line);
        batch.count = batch.count + 2'd1;
        do_idle = 1'b1;
      end
      M_STRING: begin
        if (text_byte == CH_NUL) begin
          batch.res[batch.count] = mk(EV_SEND, CH_NUL, tok_line);
          batch.count = batch.count + 2'd1;
          do_idle = 1'b1;
        end else if (text_byte == CH_QUOTE) begin
          batch.res[batch.count] = mk(EV_SEND, CH_NUL, tok_line);
          batch.count = batch.count + 2'd1;
          string_length_next = '0;
          mode_next = M_IDLE;
        end else if (text_byte == CH_BACKSLASH) begin
          mode_next = M_ESCAPE;
        end else begin
          do_sbyte = 1'b1;
        end
      end
      M_ESCAPE: begin
        if (text_byte == CH_NUL) begin
          batch.res[batch.count] = mk(EV_SEND, CH_NUL, tok_line);
          batch.count = batch.count + 2'd1;
          do_idle = 1'b1;
        end else begin
          if (text_byte == CH_LOWER_N) decoded = CH_LF;
          else if (text_byte == CH_LOWER_T) decoded = CH_TAB;
          do_sbyte = 1'b1;
        end
      end
      M_CUT: begin
        // A quote right after a cut string is the dropped closing quote.
        mode_next = M_IDLE;
        if (text_byte != CH_QUOTE) do_idle = 1'b1;
      end
      M_IDLE: begin
        do_idle = 1'b1;
      end
    endcase

    if (do_sbyte) begin
      batch.res[batch.count] = mk(EV_SBYTE, decoded, tok_line);
      batch.count = batch.count + 2'd1;
      if (len_inc >= LEN_LIMIT) begin
        batch.res[batch.count] = mk(EV_SEND, CH_NUL, tok_line);
        batch.count = batch.count + 2'd1;
        string_length_next = '0;
        mode_next = M_CUT;
      end else begin
        string_length_next = len_inc;
        mode_next = M_STRING;
      end
    end

    if (do_idle) begin
      mode_next = M_IDLE;
      priority if (text_byte == CH_NUL) begin
        batch.res[batch.count] = mk(EV_EOT, CH_NUL, cur_line);
        batch.count = batch.count + 2'd1;
        line_count_next    = LINE_ONE;
        start_line_next    = LINE_ONE;
        string_length_next = '0;
      end else if (text_byte == CH_LF) begin
        if (line_count != LINE_MAX) line_count_next = line_count + LINE_ONE;
      end else if (is_space(text_byte)) begin
        mode_next = M_IDLE;
      end else if (text_byte == CH_SLASH) begin
        start_line_next = line_count;
        mode_next = M_SLASH;
      end else if (text_byte == CH_LBRACE) begin
        batch.res[batch.count] = mk(EV_LBR, CH_NUL, cur_line);
        batch.count = batch.count + 2'd1;
      end else if (text_byte == CH_RBRACE) begin
        batch.res[batch.count] = mk(EV_RBR, CH_NUL, cur_line);
        batch.count = batch.count + 2'd1;
      end else if (text_byte == CH_QUOTE) begin
        start_line_next    = line_count;
        string_length_next = '0;
        mode_next = M_STRING;
      end else begin
        start_line_next = line_count;
        batch.res[batch.count] = mk(EV_IBYTE, text_byte, cur_line);
        batch.count = batch.count + 2'd1;
        mode_next = (is_alnum(text_byte) || text_byte == CH_UNDERSCORE) ? M_IDENT : M_SINGLE;
      end
    end

    if (batch.count != 2'd0) begin
      batch.res[batch.count - 2'd1].last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      line_count    <= LINE_ONE;
      start_line    <= LINE_ONE;
      string_length <= '0;
    end else if (step) begin
      mode          <= mode_next;
      line_count    <= line_count_next;
      start_line    <= start_line_next;
      string_length <= string_length_next;
    end
  end

endmodule

>>> design/kvt_outq.sv
// ----------------------------------------------------------------------------
// kvt_outq
// Four-entry result queue that shifts towards the output register and takes
// a whole batch of results in a single push.
// ----------------------------------------------------------------------------
module kvt_outq import kvt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  kvt_batch_t  batch,
  output logic        room,
  output logic        m_valid,
  input  logic        m_ready,
  output kvt_result_t head,
  output logic [2:0]  fill
);

  kvt_result_t [QUEUE_DEPTH-1:0] slots, slots_next;
  logic [2:0] cnt, cnt_next, base;
  logic       pop;

  assign pop     = m_valid & m_ready;
  assign m_valid = (cnt != 3'd0);
  assign head    = slots[0];
  assign fill    = cnt;
  // Room for a full batch whatever happens at the output this cycle.
  assign room    = (cnt <= 3'd1);

  always_comb begin
    logic [2:0] off;
    base = cnt - {2'b00, pop};
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && i < QUEUE_DEPTH - 1) slots_next[i] = slots[i + 1];
      else                            slots_next[i] = slots[i];
      off = 3'(i) - base;
      if (push && 3'(i) >= base && off < {1'b0, batch.count}) begin
        slots_next[i] = batch.res[off[1:0]];
      end
    end
    cnt_next = base + (push ? {1'b0, batch.count} : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
    slots <= slots_next;
  end

endmodule

>>> design/keyvalue_text_tokenizer.sv
// ----------------------------------------------------------------------------
// keyvalue_text_tokenizer
// Streaming lexer for key/value resource text: braces, quoted strings and
// bare identifiers, one text byte per request.
// ----------------------------------------------------------------------------
// Usage
// The slave side takes one text byte per request in s_tdata; a zero byte ends
// the text and returns the lexer to its start state after emitting the end
// of text event. The master side gives one result per request: the event
// kind in m_tuser, the decoded byte and the token's starting line in m_tdata,
// and m_tlast on the last result caused by an input byte. A byte may cause
// no result at all (whitespace, comments, the opening quote).
// Each accepted byte is decoded in the same cycle and its results (up to
// three) are written into a four-entry output queue, which presents a
// result on the next cycle. A byte is taken whenever the queue holds at
// most one result, which gives one byte per cycle while each byte causes at
// most one result and the receiver takes every result. A byte that causes
// two or three results holds up the input until the queue drains to one.
// Reset empties the queue and sets the line counter to one. When the
// receiver stalls, results wait in the queue and the input stops once more
// than one is waiting; nothing is dropped.
// ----------------------------------------------------------------------------
module keyvalue_text_tokenizer import kvt_pkg::*; #(
  parameter int STRING_BUFFER = 4096,
  parameter int LINE_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] token_byte, [23:8] token_line
  output logic [2:0]  m_tuser,   // [2:0] event_res
  output logic        m_tlast    // last_of_run
);

  kvt_batch_t  batch;
  kvt_result_t head;
  logic        accept;
  logic        room;
  logic [2:0]  fill;

  assign accept   = s_tvalid & s_tready;
  assign s_tready = room;

  kvt_lexer #(
    .STRING_BUFFER (STRING_BUFFER),
    .LINE_BITS     (LINE_BITS)
  ) u_lexer (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .text_byte (s_tdata),
    .batch     (batch)
  );

  kvt_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .push    (accept),
    .batch   (batch),
    .room    (room),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .head    (head),
    .fill    (fill)
  );

  assign m_tdata = {head.token_line, head.token_byte};
  assign m_tuser = head.event_res;
  assign m_tlast = head.last_of_run;

  // The queue never overflows its four entries.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 3'd4)
    else $error("result queue overflow");

  // A result that is not the last of its byte always has a successor queued.
  a_run_complete: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (fill >= 3'd2))
    else $error("result run split across input bytes");

  // Only byte events carry a byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != EV_SBYTE && m_tuser != EV_IBYTE) |-> (m_tdata[7:0] == 8'h00))
    else $error("non-byte event carries a byte");

  // Nothing is presented in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid straight after reset");

  // An accepted byte that yields results shows one on the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && batch.count != 2'd0) |=> m_tvalid)
    else $error("result missing after accepted byte");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keyvalue_text_tokenizer. Text bytes are streamed in
// with random gaps while the result side stalls at random. A behavioural
// lexer predicts the tokens that each byte should produce, and every result
// is matched against the oldest prediction. The stimulus covers directed
// corner cases and a run of random, mostly well-formed resource text.
// ----------------------------------------------------------------------------
module tb;
  import kvt_pkg::*;

  localparam int          STR_BUF    = 4096;
  localparam int          LINE_BITS  = 16;
  localparam logic [15:0] LINE_MAX   = 16'((64'd1 << LINE_BITS) - 1);
  localparam int          IDLE_LIMIT = 2000;
  localparam int          HOLD_OFF   = 300;
  localparam int          RAND_BYTES = 75;
  localparam logic [7:0]  CH_VTAB    = 8'h0B;
  localparam logic [7:0]  CH_FFEED   = 8'h0C;

  typedef enum logic [2:0] {
    LX_IDLE, LX_SLASH, LX_COMMENT, LX_IDENT, LX_SINGLE, LX_STRING, LX_ESCAPE, LX_CUT
  } lex_mode_t;

  class token_scoreboard;
    kvt_result_t expected_q[$];
    int          errors;
    int          bytes_fed;
    int          results_checked;
    lex_mode_t   mode;
    logic [15:0] line_no;
    logic [15:0] tok_line;
    int          str_len;

    function new();
      errors = 0;
      bytes_fed = 0;
      results_checked = 0;
      restart();
    endfunction

    function void restart();
      mode = LX_IDLE;
      line_no = 16'd1;
      tok_line = 16'd1;
      str_len = 0;
    endfunction

    function void push(kvt_event_t ev, logic [7:0] b, logic [15:0] ln);
      kvt_result_t r;
      r.event_res = ev;
      r.token_byte = b;
      r.token_line = ln;
      r.last_of_run = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void next_line();
      if (line_no != LINE_MAX) line_no++;
    endfunction

    function bit is_word_char(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function bit continues_ident(logic [7:0] c);
      return is_word_char(c) || c == CH_UNDERSCORE || c == CH_DASH || c == CH_DOT ||
             c == CH_COLON || c == CH_SLASH || c == CH_BACKSLASH;
    endfunction

    function void take_between_tokens(logic [7:0] c);
      mode = LX_IDLE;
      if (c == CH_NUL) begin
        push(EV_EOT, 8'd0, line_no);
        restart();
      end else if (c == CH_LF) begin
        next_line();
      end else if (is_blank(c)) begin
        // Other whitespace is skipped without effect.
      end else if (c == CH_SLASH) begin
        tok_line = line_no;
        mode = LX_SLASH;
      end else if (c == CH_LBRACE) begin
        push(EV_LBR, 8'd0, line_no);
      end else if (c == CH_RBRACE) begin
        push(EV_RBR, 8'd0, line_no);
      end else if (c == CH_QUOTE) begin
        tok_line = line_no;
        str_len = 0;
        mode = LX_STRING;
      end else begin
        tok_line = line_no;
        push(EV_IBYTE, c, tok_line);
        mode = (is_word_char(c) || c == CH_UNDERSCORE) ? LX_IDENT : LX_SINGLE;
      end
    endfunction

    function void string_char(logic [7:0] d);
      push(EV_SBYTE, d, tok_line);
      str_len++;
      if (str_len + 1 >= STR_BUF) begin
        push(EV_SEND, 8'd0, tok_line);
        str_len = 0;
        mode = LX_CUT;
      end else begin
        mode = LX_STRING;
      end
    endfunction

    // Works out the results of one accepted text byte.
    function void note_byte(logic [7:0] c);
      int          size_prev;
      kvt_result_t r;
      size_prev = expected_q.size();
      bytes_fed++;
      case (mode)
        LX_SLASH: begin
          if (c == CH_SLASH) begin
            mode = LX_COMMENT;
          end else begin
            push(EV_IBYTE, CH_SLASH, tok_line);
            push(EV_IEND, 8'd0, tok_line);
            take_between_tokens(c);
          end
        end
        LX_COMMENT: begin
          if (c == CH_NUL) begin
            take_between_tokens(c);
          end else if (c == CH_LF) begin
            next_line();
            mode = LX_IDLE;
          end
        end
        LX_IDENT: begin
          if (c != CH_NUL && continues_ident(c)) begin
            push(EV_IBYTE, c, tok_line);
          end else begin
            push(EV_IEND, 8'd0, tok_line);
            take_between_tokens(c);
          end
        end
        LX_SINGLE: begin
          push(EV_IEND, 8'd0, tok_line);
          take_between_tokens(c);
        end
        LX_STRING: begin
          if (c == CH_NUL) begin
            push(EV_SEND, 8'd0, tok_line);
            take_between_tokens(c);
          end else if (c == CH_QUOTE) begin
            push(EV_SEND, 8'd0, tok_line);
            str_len = 0;
            mode = LX_IDLE;
          end else if (c == CH_BACKSLASH) begin
            mode = LX_ESCAPE;
          end else begin
            string_char(c);
          end
        end
        LX_ESCAPE: begin
          if (c == CH_NUL) begin
            push(EV_SEND, 8'd0, tok_line);
            take_between_tokens(c);
          end else begin
            string_char(c == CH_LOWER_N ? CH_LF : c == CH_LOWER_T ? CH_TAB : c);
          end
        end
        LX_CUT: begin
          // A quote straight after a cut string is swallowed.
          mode = LX_IDLE;
          if (c != CH_QUOTE) take_between_tokens(c);
        end
        default: take_between_tokens(c);
      endcase
      if (expected_q.size() > size_prev) begin
        r = expected_q.pop_back();
        r.last_of_run = 1'b1;
        expected_q.push_back(r);
      end
    endfunction

    function void check_result(logic [2:0] ev, logic [7:0] b, logic [15:0] ln, logic last);
      kvt_result_t r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: event_res %0d, token_byte %0h, token_line %0d",
               ev, b, ln);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      results_checked++;
      if (ev !== r.event_res) begin
        $error("event_res: expected %0d, got %0d", r.event_res, ev);
        errors++;
      end
      if (b !== r.token_byte) begin
        $error("token_byte: expected %0h, got %0h", r.token_byte, b);
        errors++;
      end
      if (ln !== r.token_line) begin
        $error("token_line: expected %0d, got %0d", r.token_line, ln);
        errors++;
      end
      if (last !== r.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", r.last_of_run, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] text_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // [7:0] token_byte, [23:8] token_line
  logic [2:0]  m_tuser;          // [2:0] event_res
  logic        m_tlast;

  token_scoreboard sb;
  bit              fast_feed = 1'b0;
  bit              hold_off_req = 1'b0;
  int              idle_cycles = 0;

  keyvalue_text_tokenizer #(
    .STRING_BUFFER(STR_BUF),
    .LINE_BITS    (LINE_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always #10 clk = ~clk;

  // Mostly short pauses, with the odd long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    bit taken;
    gap = fast_feed ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    sb.note_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_char(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] escape_char();
    case ($urandom_range(0, 5))
      0: return CH_LOWER_N;
      1: return CH_LOWER_T;
      2: return CH_QUOTE;
      3: return CH_BACKSLASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_token();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      send_byte($urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE);
    end else if (kind < 40) begin
      send_byte(CH_QUOTE);
      n = $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) begin
          send_byte(CH_BACKSLASH);
          send_byte(escape_char());
        end else begin
          send_byte(8'($urandom_range(1, 255)));
        end
      end
      if ($urandom_range(0, 9) != 0) send_byte(CH_QUOTE);
    end else if (kind < 62) begin
      send_byte(pick_char("azAZ09_kQ5"));
      n = $urandom_range(0, 5);
      repeat (n) send_byte(pick_char("azAZ09_-.:/\\"));
    end else if (kind < 77) begin
      case ($urandom_range(0, 5))
        0: send_byte(CH_SPACE);
        1: send_byte(CH_TAB);
        2: send_byte(CH_VTAB);
        3: send_byte(CH_FFEED);
        4: send_byte(CH_CR);
        default: send_byte(CH_LF);
      endcase
    end else if (kind < 85) begin
      send_text("//");
      n = $urandom_range(0, 4);
      repeat (n) send_byte(8'($urandom_range(1, 255)));
      if ($urandom_range(0, 4) != 0) send_byte(CH_LF);
    end else if (kind < 97) begin
      send_byte(8'($urandom_range(1, 255)));
    end else begin
      send_byte(CH_NUL);
    end
  endtask

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    int n;
    wait (!rst);
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (hold_off_req) begin
        n = HOLD_OFF;
        hold_off_req = 1'b0;
      end
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8))
        @(posedge clk);
    end
  end

  // Results are sampled mid-cycle and checked at the edge that takes them.
  initial begin
    bit          got;
    logic [2:0]  ev;
    logic [23:0] data;
    logic        last;
    forever begin
      @(negedge clk);
      got = !rst && m_tvalid && m_tready;
      ev = m_tuser;
      data = m_tdata;
      last = m_tlast;
      @(posedge clk);
      if (got) sb.check_result(ev, data[7:0], data[23:8], last);
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Timeout: no request taken for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int start_count;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every token kind, escapes, slash handling, high bytes and open
    // slash, escape, comment, identifier and single-byte tokens at end of text.
    send_text("{a_-.:/\\ \"x\\n\\t\\q\\\"\t\"}\n");
    send_text("/{/ //}\n");
    send_byte(CH_VTAB);
    send_byte(CH_FFEED);
    send_byte(CH_CR);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(CH_NUL);
    send_text("/");
    send_byte(CH_NUL);
    send_text("\"\\");
    send_byte(CH_NUL);
    send_text("//");
    send_byte(CH_NUL);
    send_text("k");
    send_byte(CH_NUL);
    send_text("{k \"s\"");
    send_byte(CH_NUL);

    // Random resource text; the receiver holds off early on so that the
    // output queue backs up into the input.
    hold_off_req = 1'b1;
    start_count = sb.bytes_fed;
    while (sb.bytes_fed - start_count < RAND_BYTES) begin
      if ($urandom_range(0, 7) == 0) fast_feed = !fast_feed;
      send_random_token();
    end
    fast_feed = 1'b0;
    s_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Fed %0d text bytes and checked %0d results under random stalls,",
             sb.bytes_fed, sb.results_checked);
    $display("covering every token kind, escapes, open tokens at end of text and random text.");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
